### design/agh_pkg.sv
package agh_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_HALO_RADIUS  = 3'd2;
   localparam logic [2:0] REG_GLOW_RGB     = 3'd3;
   localparam logic [2:0] REG_GLOW_GAIN    = 3'd4;

   localparam int unsigned ALPHA_MAX = 255;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_DIV,
      ST_SCALE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [31:0] in_pixel;
      logic        is_flush;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_pixel;
      logic        end_of_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [23:0] data;
   } csr_payload_type;

endpackage

### design/agh_if.sv
interface agh_req_if;
   import agh_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface agh_rsp_if;
   import agh_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface agh_csr_if;
   import agh_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/agh_divider.sv
// Restoring divider, one quotient bit per cycle.
module agh_divider #(
   parameter int NBITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NBITS-1:0] dividend,
   input  logic [NBITS-1:0] divisor,
   output logic             done,
   output logic [NBITS-1:0] quotient
);
   localparam int CW = $clog2(NBITS + 1);

   logic [NBITS-1:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [NBITS:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NBITS-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CW'(NBITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = NBITS'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[NBITS-2:0], 1'b1};
         end else begin
            rem_in = trial[NBITS-1:0];
            quo_in = {quo_ff[NBITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/alpha_glow_halo_unit.sv
// Alpha glow filter. ARGB pixels enter in raster order and leave in the same
// order, delayed by radius rows plus radius pixels; flush transactions drain
// the held pixels after the frame ends. An opaque pixel passes unchanged; a
// transparent one receives the glow color with an alpha made from the sum of
// alpha over the (2r+1) square window, divided by (2r-1)^2, scaled by the
// 8.8 gain and clamped to 255. One transaction is handled at a time; a
// transparent pixel adds the window reads through the single read port of
// the pixel store, the bit serial divider (15 quotient bits at the default
// maximum radius) and the gain scale. A result that waits on the receiver
// holds back only the next result, not the next transaction. Store contents
// are not cleared after reset; only pixels of the current frame are read.
module alpha_glow_halo_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 4
) (
   input  logic      clock,
   input  logic      reset,
   agh_req_if.sink   req,
   agh_rsp_if.source rsp,
   agh_csr_if.sink   csr
);
   import agh_pkg::*;

   localparam int XW     = $clog2(MAX_WIDTH + 1);
   localparam int YW     = $clog2(MAX_HEIGHT + 1);
   localparam int RW     = $clog2(MAX_RADIUS + 1);
   localparam int DEPTH  = (2 * MAX_RADIUS + 2) * MAX_WIDTH;
   localparam int AW     = $clog2(DEPTH);
   localparam int OW     = AW + 2;
   localparam int PW     = XW + YW;
   localparam int SW     = $clog2(255 * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
   localparam int DW     = (SW > 8) ? SW : 8;

   // Configuration registers
   logic [10:0] width_ff, height_ff;
   logic [2:0]  radius_ff;
   logic [23:0] rgb_ff;
   logic [15:0] gain_ff;
   logic        geom_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 11'd1024;
         radius_ff <= 3'd1;
         rgb_ff    <= 24'hFFFFFF;
         gain_ff   <= 16'd256;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.data.index)
            REG_FRAME_WIDTH:  width_ff  <= csr.data.data[10:0];
            REG_FRAME_HEIGHT: height_ff <= csr.data.data[10:0];
            REG_HALO_RADIUS:  radius_ff <= csr.data.data[2:0];
            REG_GLOW_RGB:     rgb_ff    <= csr.data.data;
            REG_GLOW_GAIN:    gain_ff   <= csr.data.data[15:0];
            default: ;
         endcase
      end
   end
   assign geom_wr = csr.valid && csr.ready && (csr.data.index == REG_FRAME_WIDTH ||
                    csr.data.index == REG_FRAME_HEIGHT || csr.data.index == REG_HALO_RADIUS);

   // Effective geometry
   logic [XW-1:0] w;
   logic [YW-1:0] h;
   logic [RW-1:0] r;
   always_comb begin
      if (width_ff == 11'd0) w = XW'(1);
      else if (32'(width_ff) > 32'(MAX_WIDTH)) w = XW'(MAX_WIDTH);
      else w = XW'(width_ff);
      if (height_ff == 11'd0) h = YW'(1);
      else if (32'(height_ff) > 32'(MAX_HEIGHT)) h = YW'(MAX_HEIGHT);
      else h = YW'(height_ff);
      if (32'(radius_ff) > 32'(MAX_RADIUS)) r = RW'(MAX_RADIUS);
      else r = RW'(radius_ff);
   end

   // Linear positions, kept incrementally
   logic [XW-1:0] col_ff, col_in, ecol_ff, ecol_in;
   logic [YW-1:0] row_ff, row_in, erow_ff, erow_in;
   logic [PW-1:0] inc_ff, inc_in, emc_ff, emc_in;
   logic [PW-1:0] total_ff, delay_ff;

   // Store addresses of the input and emit positions, wrapping at the depth
   logic [AW-1:0] waddr_ff, waddr_in, eaddr_ff, eaddr_in;

   // Totals recomputed from the geometry; one multiply each, registered
   always_ff @(posedge clock) begin
      total_ff <= PW'(w) * PW'(h);
      delay_ff <= PW'(r) * PW'(w) + PW'(r);
   end

   state_type state_ff, state_in;
   req_payload_type item_ff;
   logic [AW-1:0] store_addr;
   logic [31:0]   store_q_ff;
   logic          store_we;
   logic [AW-1:0] store_waddr;
   logic [31:0]   mem [DEPTH];

   // Pixel store
   always_ff @(posedge clock) begin
      if (store_we) mem[store_waddr] <= item_ff.in_pixel;
      store_q_ff <= mem[store_addr];
   end

   // Window walk
   logic signed [RW+1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic                 acc_ff, acc_in, samp_ok_ff, samp_ok_in;
   logic                 first_ff, first_in;
   logic                 fwd_ff, fwd_in;
   logic [31:0]          center_ff, center_in, center_rd;
   logic [31:0]          pix_ff, pix_in;
   logic [DW-1:0]        q;
   logic                 div_start, div_done;
   logic [DW-1:0]        divisor;
   logic [DW+15:0]       prod_ff;
   logic [7:0]           alpha_ff, alpha_in;
   rsp_payload_type      out_ff, out_in;
   logic                 ovalid_ff, ovalid_in;

   logic signed [YW+1:0] sy;
   logic signed [XW+1:0] sx;
   logic signed [OW-1:0] offs, saddr;
   logic [AW-1:0]        samp_addr;
   logic                 in_frame;
   logic [RW+1:0]        d;

   assign d       = {1'b0, r, 1'b0} - (RW+2)'(1);
   assign divisor = (r == '0) ? DW'(1) : DW'(d) * DW'(d);

   // Center comes straight from the transaction when it was written this pass
   assign center_rd = fwd_ff ? item_ff.in_pixel : store_q_ff;

   always_comb begin
      sy = $signed({2'b0, erow_ff}) + (YW+2)'(dy_ff);
      sx = $signed({2'b0, ecol_ff}) + (XW+2)'(dx_ff);
      in_frame = (sy >= 0) && (sy < $signed({2'b0, h})) &&
                 (sx >= 0) && (sx < $signed({2'b0, w}));
      // sample address relative to the emit position, folded into the store
      offs  = OW'(dy_ff) * OW'($signed({1'b0, w})) + OW'(dx_ff);
      saddr = $signed({2'b0, eaddr_ff}) + offs;
      if (saddr < 0) samp_addr = AW'(saddr + OW'(DEPTH));
      else if (saddr >= OW'(DEPTH)) samp_addr = AW'(saddr - OW'(DEPTH));
      else samp_addr = AW'(saddr);
   end

   agh_divider #(.NBITS(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DW'(sum_ff)),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (q)
   );

   logic emit_ok;
   logic [PW-1:0] inc_now;
   logic [DW+15:0] prod_sh;

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      ecol_in    = ecol_ff;
      erow_in    = erow_ff;
      inc_in     = inc_ff;
      emc_in     = emc_ff;
      waddr_in   = waddr_ff;
      eaddr_in   = eaddr_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sum_in     = sum_ff;
      acc_in     = 1'b0;
      samp_ok_in = samp_ok_ff;
      first_in   = 1'b0;
      fwd_in     = 1'b0;
      center_in  = center_ff;
      pix_in     = pix_ff;
      alpha_in   = alpha_ff;
      out_in     = out_ff;
      ovalid_in  = ovalid_ff;
      store_we   = 1'b0;
      store_waddr = waddr_ff;
      store_addr = eaddr_ff;
      div_start  = 1'b0;
      inc_now    = inc_ff;
      emit_ok    = 1'b0;
      prod_sh    = prod_ff >> 8;
      if (rsp.ready) ovalid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_READ: begin
            // store the pixel unless it is a flush or beyond the frame, then decide whether to emit
            if (!item_ff.is_flush && inc_ff < total_ff) begin
               store_we = 1'b1;
               fwd_in   = (waddr_ff == eaddr_ff);
               waddr_in = (waddr_ff == AW'(DEPTH - 1)) ? '0 : waddr_ff + 1'b1;
               inc_now  = inc_ff + 1'b1;
               inc_in   = inc_now;
               if (col_ff + 1'b1 >= w) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            emit_ok = (emc_ff < inc_now) &&
                      (inc_now == total_ff || inc_now - emc_ff > delay_ff);
            if (!emit_ok) begin
               state_in = ST_IDLE;
            end else begin
               dy_in    = -$signed({2'b0, r});
               dx_in    = -$signed({2'b0, r});
               sum_in   = '0;
               first_in = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // one window sample per cycle through the single read port
            if (first_ff) center_in = center_rd;
            if (!first_ff && center_ff[31:24] != 8'd0) begin
               pix_in   = center_ff;
               state_in = ST_OUT;
            end else if (first_ff && center_rd[31:24] != 8'd0) begin
               pix_in   = center_rd;
               state_in = ST_OUT;
            end else begin
               if (acc_ff && samp_ok_ff) sum_in = sum_ff + SW'(store_q_ff[31:24]);
               if (dy_ff > $signed({2'b0, r})) begin
                  if (!acc_ff) begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end else begin
                  store_addr = samp_addr;
                  samp_ok_in = in_frame;
                  acc_in     = 1'b1;
                  if (dx_ff == $signed({2'b0, r})) begin
                     dx_in = -$signed({2'b0, r});
                     dy_in = dy_ff + 1'b1;
                  end else begin
                     dx_in = dx_ff + 1'b1;
                  end
               end
            end
         end
         ST_DIV: if (div_done) state_in = ST_SCALE;
         ST_SCALE: begin
            // prod_ff holds quotient times gain
            if (prod_sh > (DW+16)'(ALPHA_MAX)) alpha_in = 8'(ALPHA_MAX);
            else alpha_in = prod_sh[7:0];
            state_in = ST_OUT;
            if (alpha_in == 8'd0) pix_in = '0;
            else pix_in = {alpha_in, rgb_ff};
         end
         ST_OUT: begin
            // hand over the result once the output register is free
            if (!ovalid_ff || rsp.ready) begin
               ovalid_in = 1'b1;
               out_in.out_pixel = pix_ff;
               out_in.end_of_frame = (emc_ff + 1'b1 == total_ff);
               if (emc_ff + 1'b1 == total_ff) begin
                  col_in = '0; row_in = '0; ecol_in = '0; erow_in = '0;
                  inc_in = '0; emc_in = '0;
                  waddr_in = '0; eaddr_in = '0;
               end else begin
                  emc_in = emc_ff + 1'b1;
                  eaddr_in = (eaddr_ff == AW'(DEPTH - 1)) ? '0 : eaddr_ff + 1'b1;
                  if (ecol_ff + 1'b1 >= w) begin
                     ecol_in = '0;
                     erow_in = erow_ff + 1'b1;
                  end else begin
                     ecol_in = ecol_ff + 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_IDLE && req.valid) state_in = ST_READ;
      if (geom_wr) begin
         col_in = '0; row_in = '0; ecol_in = '0; erow_in = '0;
         inc_in = '0; emc_in = '0;
         waddr_in = '0; eaddr_in = '0;
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         col_ff    <= '0;
         row_ff    <= '0;
         ecol_ff   <= '0;
         erow_ff   <= '0;
         inc_ff    <= '0;
         emc_ff    <= '0;
         waddr_ff  <= '0;
         eaddr_ff  <= '0;
         ovalid_ff <= 1'b0;
         acc_ff    <= 1'b0;
         first_ff  <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         ecol_ff   <= ecol_in;
         erow_ff   <= erow_in;
         inc_ff    <= inc_in;
         emc_ff    <= emc_in;
         waddr_ff  <= waddr_in;
         eaddr_ff  <= eaddr_in;
         ovalid_ff <= ovalid_in;
         acc_ff    <= acc_in;
         first_ff  <= first_in;
         fwd_ff    <= fwd_in;
      end
      if (req.valid && req.ready) item_ff <= req.data;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      sum_ff     <= sum_in;
      samp_ok_ff <= samp_ok_in;
      center_ff  <= center_in;
      pix_ff     <= pix_in;
      alpha_ff   <= alpha_in;
      out_ff     <= out_in;
      prod_ff    <= (DW+16)'(q) * (DW+16)'(gain_ff);
   end

`ifndef SYNTHESIS
   a_emit_behind: assert property (@(posedge clock) disable iff (reset)
      emc_ff <= inc_ff) else $error("emit position passed input position");
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("ready while busy");
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   a_inc_bound: assert property (@(posedge clock) disable iff (reset)
      inc_ff <= total_ff || $past(geom_wr)) else $error("input count beyond frame");
`endif

endmodule
